>>> rtl/asod_pkg.sv
// Shared types and constants of the averaged six-way orientation detector.
package asod_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned CfgIdxW = 3;

  typedef logic signed [SampleW-1:0] sample_t;

  typedef struct packed {
    sample_t x;
    sample_t y;
    sample_t z;
  } axes_t;

  typedef struct packed {
    sample_t z_pos;
    sample_t z_neg;
    sample_t y_pos;
    sample_t y_neg;
    sample_t x_pos;
    sample_t x_neg;
  } thresholds_t;

  typedef struct packed {
    logic prod_en;
    logic avg_en;
  } div_en_t;

  typedef enum logic [2:0] {
    OrientUnknown = 3'd0,
    OrientZPos    = 3'd1,
    OrientZNeg    = 3'd2,
    OrientYNeg    = 3'd3,
    OrientYPos    = 3'd4,
    OrientXNeg    = 3'd5,
    OrientXPos    = 3'd6
  } orient_e;

  localparam logic [CfgIdxW-1:0] CfgZPosThr = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgZNegThr = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgYPosThr = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgYNegThr = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgXPosThr = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgXNegThr = 3'd5;

endpackage

>>> rtl/asod_const_div.sv
// Two-stage signed division of a window sum by a constant, truncated toward zero.
module asod_const_div
  import asod_pkg::*;
#(
  parameter int unsigned Divisor = 8,
  parameter int unsigned SumW    = 20
) (
  input  logic                   clk_i,
  input  div_en_t                en_i,
  input  logic signed [SumW-1:0] sum_i,
  output sample_t                quot_o
);

  localparam int unsigned MagW    = SumW - 1;
  localparam int unsigned ShiftK  = MagW + $clog2(Divisor);
  localparam int unsigned RecipW  = MagW + 1;
  localparam int unsigned ProdW   = MagW + RecipW;
  localparam longint unsigned Recip =
    ((64'd1 << ShiftK) + longint'(Divisor) - 64'd1) / longint'(Divisor);
  localparam logic [RecipW-1:0] RecipC = RecipW'(Recip);

  logic [SumW-1:0]    abs_full;
  logic [MagW-1:0]    mag;
  logic [ProdW-1:0]   prod_d, prod_q;
  logic               neg_q;
  logic [SampleW:0]   quot_mag;
  logic [SampleW:0]   quot_signed;
  sample_t            quot_d, quot_q;

  assign abs_full = sum_i[SumW-1] ? (~sum_i + 1'b1) : sum_i;
  assign mag      = abs_full[MagW-1:0];
  assign prod_d   = ProdW'(mag) * ProdW'(RecipC);

  always_ff @(posedge clk_i) begin
    if (en_i.prod_en) begin
      prod_q <= prod_d;
      neg_q  <= sum_i[SumW-1];
    end
  end

  assign quot_mag    = (SampleW + 1)'(prod_q >> ShiftK);
  assign quot_signed = neg_q ? (~quot_mag + 1'b1) : quot_mag;
  assign quot_d      = quot_signed[SampleW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i.avg_en) begin
      quot_q <= quot_d;
    end
  end

  assign quot_o = quot_q;

endmodule

>>> rtl/asod_classify.sv
// Orientation decision from the three axis averages and the thresholds.
module asod_classify
  import asod_pkg::*;
(
  input  axes_t       avg_i,
  input  thresholds_t thr_i,
  output orient_e     orient_o
);

  function automatic logic [SampleW:0] magnitude(sample_t v);
    logic [SampleW:0] ext;
    ext = {v[SampleW-1], v};
    return v[SampleW-1] ? (~ext + 1'b1) : ext;
  endfunction

  logic [SampleW:0] mag_x, mag_y, mag_z;
  logic             dom_x, dom_y, dom_z;

  assign mag_x = magnitude(avg_i.x);
  assign mag_y = magnitude(avg_i.y);
  assign mag_z = magnitude(avg_i.z);

  assign dom_x = (mag_x > mag_y) && (mag_x > mag_z);
  assign dom_y = (mag_y > mag_x) && (mag_y > mag_z);
  assign dom_z = (mag_z > mag_x) && (mag_z > mag_y);

  always_comb begin
    if (dom_z && (avg_i.z > thr_i.z_pos)) begin
      orient_o = OrientZPos;
    end else if (dom_z && (avg_i.z < thr_i.z_neg)) begin
      orient_o = OrientZNeg;
    end else if (dom_y && (avg_i.y < thr_i.y_neg)) begin
      orient_o = OrientYNeg;
    end else if (dom_y && (avg_i.y > thr_i.y_pos)) begin
      orient_o = OrientYPos;
    end else if (dom_x && (avg_i.x < thr_i.x_neg)) begin
      orient_o = OrientXNeg;
    end else if (dom_x && (avg_i.x > thr_i.x_pos)) begin
      orient_o = OrientXPos;
    end else begin
      orient_o = OrientUnknown;
    end
  end

endmodule

>>> rtl/averaged_six_way_orientation_detector.sv
// Top level of the averaged six-way orientation detector.
//
// Each accepted input word is one signed X, Y, Z accelerometer sample. It
// replaces the oldest sample of a ring of WINDOW_LENGTH samples per axis, and
// the running sums are updated at the accepting edge. The window averages are
// the sums divided by WINDOW_LENGTH, truncated toward zero, and one output word
// carries them together with the orientation code.
// The thresholds are to be written through the configuration port only while
// the block is idle; the block itself does not enforce it. An accepted word
// passes the running sum, reciprocal multiply, average, then classification
// into the output register. One word is taken per cycle unless the receiver
// stalls; the four stages hold their words in a stall, and the input keeps
// taking words until every stage is full. Reset empties the window, clears
// the sums, the thresholds and every stage valid flag, losing words in flight.
module averaged_six_way_orientation_detector
  import asod_pkg::*;
#(
  parameter int unsigned WINDOW_LENGTH = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [SampleW-1:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [SampleW-1:0] accel_x_i,
  input  logic [SampleW-1:0] accel_y_i,
  input  logic [SampleW-1:0] accel_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         orientation_o,
  output logic [SampleW-1:0] average_x_o,
  output logic [SampleW-1:0] average_y_o,
  output logic [SampleW-1:0] average_z_o
);

  localparam int unsigned SlotW = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int unsigned SumW  = SampleW + $clog2(WINDOW_LENGTH) + 1;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(WINDOW_LENGTH - 1);

  thresholds_t thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgZPosThr: thr_q.z_pos <= cfg_data_i;
        CfgZNegThr: thr_q.z_neg <= cfg_data_i;
        CfgYPosThr: thr_q.y_pos <= cfg_data_i;
        CfgYNegThr: thr_q.y_neg <= cfg_data_i;
        CfgXPosThr: thr_q.x_pos <= cfg_data_i;
        CfgXNegThr: thr_q.x_neg <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  logic    sum_vld_q, prod_vld_q, avg_vld_q, out_vld_q;
  logic    out_free, avg_free, prod_free, sum_free;
  logic    in_acc;
  div_en_t div_en;

  assign out_free  = !out_vld_q || out_ready_i;
  assign avg_free  = !avg_vld_q || out_free;
  assign prod_free = !prod_vld_q || avg_free;
  assign sum_free  = !sum_vld_q || prod_free;
  assign in_ready_o = sum_free;
  assign in_acc     = in_valid_i && sum_free;

  assign div_en.prod_en = sum_vld_q && prod_free;
  assign div_en.avg_en  = prod_vld_q && avg_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_vld_q  <= 1'b0;
      prod_vld_q <= 1'b0;
      avg_vld_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (sum_free) begin
        sum_vld_q <= in_acc;
      end
      if (prod_free) begin
        prod_vld_q <= sum_vld_q;
      end
      if (avg_free) begin
        avg_vld_q <= prod_vld_q;
      end
      if (out_free) begin
        out_vld_q <= avg_vld_q;
      end
    end
  end

  // The ring is filled in slot order and is not reset; before the first wrap
  // old_eff reads as zero, since filled_q is still clear.
  axes_t            ring_mem [WINDOW_LENGTH];
  axes_t            smp_in;
  axes_t            old_q;
  axes_t            old_eff;
  logic [SlotW-1:0] slot_q, slot_next;
  logic             filled_q;

  assign smp_in    = '{x: accel_x_i, y: accel_y_i, z: accel_z_i};
  assign slot_next = (slot_q == LastSlot) ? '0 : slot_q + 1'b1;
  assign old_eff   = filled_q ? old_q : '0;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ring_mem[slot_q] <= smp_in;
      if (slot_next == slot_q) begin
        old_q <= smp_in;
      end else begin
        old_q <= ring_mem[slot_next];
      end
    end
  end

  logic signed [SumW-1:0] sum_x_q, sum_y_q, sum_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q   <= '0;
      filled_q <= 1'b0;
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      sum_z_q  <= '0;
    end else if (in_acc) begin
      slot_q <= slot_next;
      if (slot_q == LastSlot) begin
        filled_q <= 1'b1;
      end
      sum_x_q <= sum_x_q + SumW'(smp_in.x) - SumW'(old_eff.x);
      sum_y_q <= sum_y_q + SumW'(smp_in.y) - SumW'(old_eff.y);
      sum_z_q <= sum_z_q + SumW'(smp_in.z) - SumW'(old_eff.z);
    end
  end

  axes_t avg;

  asod_const_div #(.Divisor(WINDOW_LENGTH), .SumW(SumW)) u_div_x (
    .clk_i  (clk_i),
    .en_i   (div_en),
    .sum_i  (sum_x_q),
    .quot_o (avg.x)
  );

  asod_const_div #(.Divisor(WINDOW_LENGTH), .SumW(SumW)) u_div_y (
    .clk_i  (clk_i),
    .en_i   (div_en),
    .sum_i  (sum_y_q),
    .quot_o (avg.y)
  );

  asod_const_div #(.Divisor(WINDOW_LENGTH), .SumW(SumW)) u_div_z (
    .clk_i  (clk_i),
    .en_i   (div_en),
    .sum_i  (sum_z_q),
    .quot_o (avg.z)
  );

  orient_e orient_d, orient_q;
  axes_t   avg_out_q;

  asod_classify u_classify (
    .avg_i    (avg),
    .thr_i    (thr_q),
    .orient_o (orient_d)
  );

  always_ff @(posedge clk_i) begin
    if (avg_vld_q && out_free) begin
      orient_q  <= orient_d;
      avg_out_q <= avg;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign orientation_o = orient_q;
  assign average_x_o   = avg_out_q.x;
  assign average_y_o   = avg_out_q.y;
  assign average_z_o   = avg_out_q.z;

endmodule
